FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes carried in the request.
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Fixed frame geometry.
    localparam int unsigned BITS_PER_BYTE = 8;
    localparam logic [3:0]  BIT_LAST_DATA = 4'(BITS_PER_BYTE - 1);
    localparam logic [3:0]  BIT_ACK_SLOT  = 4'(BITS_PER_BYTE);
    localparam logic [3:0]  SLOTS_BYTE    = 4'(BITS_PER_BYTE + 1);
    localparam logic [3:0]  SLOTS_COND    = 4'd1;
    localparam logic [2:0]  UNITS_BYTE    = 3'd4;
    localparam logic [2:0]  UNITS_COND    = 3'd5;

    // Reset value of the ticks-per-unit register.
    localparam logic [7:0]  TPU_RESET     = 8'd48;

    // One input request: one clock tick of the bus engine.
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } in_item_t;

    // One result: pin levels and status after the tick.
    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       nack_seen;
    } out_item_t;

endpackage

FILE: rtl/i2cm_in_stage.sv
module i2cm_in_stage import i2cm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     vld_reg;
    logic     vld_next;
    in_item_t data_reg;
    logic     take;

    // A new request may enter when the register is empty or is being drained.
    assign s_ready    = !vld_reg || advance;
    assign take       = s_valid && s_ready;
    assign item_valid = vld_reg;
    assign item       = data_reg;

    // Occupancy of the input register.
    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (advance) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= s_data;
        end
    end

endmodule

FILE: rtl/i2cm_core.sv
module i2cm_core import i2cm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       advance,
    input  in_item_t   item,
    output out_item_t  result
);

    logic [7:0] tpu_reg;
    logic [2:0] active_reg, active_next;
    logic [7:0] div_reg, div_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       nack_reg, nack_next;
    logic       ack_pend_reg, ack_pend_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       done;
    logic [8:0] tpu_eff;
    logic [2:0] phase_inc;
    logic [3:0] bit_inc;
    logic [2:0] units;
    logic [3:0] slots;
    logic       cond_cmd;

    // Pin levels for a given unit of a command, as {scl, sda}.
    function automatic logic [1:0] unit_levels(
        input logic [2:0] cmd,
        input logic [2:0] ph,
        input logic [3:0] bi,
        input logic       msb,
        input logic       ack,
        input logic       scl_now,
        input logic       sda_now
    );
        logic scl_o;
        logic sda_o;
        scl_o = scl_now;
        sda_o = sda_now;
        if (cmd == CMD_START) begin
            if (ph < 3'd2) begin
                scl_o = 1'b1; sda_o = 1'b1;
            end else if (ph < 3'd4) begin
                scl_o = 1'b1; sda_o = 1'b0;
            end else begin
                scl_o = 1'b0; sda_o = 1'b0;
            end
        end else if (cmd == CMD_STOP) begin
            if (ph == 3'd0) begin
                sda_o = 1'b0;
            end else if (ph < 3'd3) begin
                scl_o = 1'b1; sda_o = 1'b0;
            end else begin
                scl_o = 1'b1; sda_o = 1'b1;
            end
        end else begin
            if (ph == 3'd0) begin
                if (bi < BIT_ACK_SLOT) begin
                    sda_o = (cmd == CMD_WRITE) ? msb : 1'b1;
                end else begin
                    sda_o = (cmd == CMD_WRITE) ? 1'b1 : !ack;
                end
            end else if (ph < 3'd3) begin
                scl_o = 1'b1;
            end else begin
                scl_o = 1'b0;
            end
        end
        return {scl_o, sda_o};
    endfunction

    assign cond_cmd = (active_reg == CMD_START) || (active_reg == CMD_STOP);
    assign units    = cond_cmd ? UNITS_COND : UNITS_BYTE;
    assign slots    = cond_cmd ? SLOTS_COND : SLOTS_BYTE;
    assign tpu_eff  = (tpu_reg == 8'd0) ? 9'd1 : {1'b0, tpu_reg};

    // One tick of the engine: start a command, or advance the unit timer.
    always_comb begin
        active_next   = active_reg;
        div_next      = div_reg;
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        nack_next     = nack_reg;
        ack_pend_next = ack_pend_reg;
        rx_hold_next  = rx_hold_reg;
        done          = 1'b0;
        phase_inc     = phase_reg + 3'd1;
        bit_inc       = bit_reg + 4'd1;
        if (active_reg == CMD_NONE) begin
            if (item.cmd >= CMD_START && item.cmd <= CMD_READ) begin
                active_next = item.cmd;
                phase_next  = 3'd0;
                bit_next    = 4'd0;
                div_next    = 8'd0;
                if (item.cmd == CMD_WRITE) begin
                    shift_next = item.tx_byte;
                end
                if (item.cmd == CMD_READ) begin
                    shift_next    = 8'd0;
                    ack_pend_next = item.ack_after_read;
                end
                {scl_next, sda_next} = unit_levels(item.cmd, 3'd0, 4'd0, shift_next[7],
                                                   ack_pend_next, scl_reg, sda_reg);
            end
        end else if ({1'b0, div_reg} + 9'd1 >= tpu_eff) begin
            div_next = 8'd0;
            // Sample SDA at the end of the second SCL-high unit.
            if (phase_reg == 3'd2) begin
                if (active_reg == CMD_WRITE && bit_reg == BIT_ACK_SLOT) begin
                    nack_next = item.sda_in;
                end
                if (active_reg == CMD_READ && bit_reg < BIT_ACK_SLOT) begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                    if (bit_reg == BIT_LAST_DATA) begin
                        rx_hold_next = shift_next;
                    end
                end
            end
            if (phase_reg == 3'd3 && active_reg == CMD_WRITE && bit_reg < BIT_ACK_SLOT) begin
                shift_next = {shift_reg[6:0], 1'b0};
            end
            phase_next = phase_inc;
            if (phase_inc >= units) begin
                phase_next = 3'd0;
                bit_next   = bit_inc;
                if (bit_inc >= slots) begin
                    bit_next    = 4'd0;
                    active_next = CMD_NONE;
                    done        = 1'b1;
                end
            end
            if (active_next != CMD_NONE) begin
                {scl_next, sda_next} = unit_levels(active_reg, phase_next, bit_next,
                                                   shift_next[7], ack_pend_reg,
                                                   scl_reg, sda_reg);
            end
        end else begin
            div_next = div_reg + 8'd1;
        end
    end

    // Result of this tick, taken from the updated state.
    always_comb begin
        result.scl_level   = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (active_next != CMD_NONE);
        result.done_res    = done;
        result.rx_byte     = rx_hold_next;
        result.nack_seen   = nack_next;
    end

    // Engine state advances once per request consumed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpu_reg      <= TPU_RESET;
            active_reg   <= CMD_NONE;
            div_reg      <= 8'd0;
            phase_reg    <= 3'd0;
            bit_reg      <= 4'd0;
            shift_reg    <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            nack_reg     <= 1'b0;
            ack_pend_reg <= 1'b0;
            rx_hold_reg  <= 8'd0;
        end else begin
            if (cfg_we) begin
                tpu_reg <= cfg_wdata;
            end
            if (advance) begin
                active_reg   <= active_next;
                div_reg      <= div_next;
                phase_reg    <= phase_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                nack_reg     <= nack_next;
                ack_pend_reg <= ack_pend_next;
                rx_hold_reg  <= rx_hold_next;
            end
        end
    end

endmodule

FILE: rtl/i2cm_out_stage.sv
module i2cm_out_stage import i2cm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  out_item_t result,
    output logic      can_load,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      vld_reg;
    logic      vld_next;
    out_item_t data_reg;

    // The register can be refilled when empty or when its content leaves now.
    assign can_load = !vld_reg || m_ready;
    assign m_valid  = vld_reg;
    assign m_data   = data_reg;

    // Occupancy of the result register.
    always_comb begin
        if (load) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

endmodule

FILE: rtl/i2c_master_byte_engine_unit.sv
// Channel   Direction  Handshake                 Payload
// s_        in         s_valid / s_ready         in_item_t  (one bus tick)
// m_        out        m_valid / m_ready         out_item_t (pin levels, status)
// cfg_      in         cfg_valid / cfg_ready     ticks_per_unit, 8 bits
//
// One request is taken per cycle unless the result side stalls; each one is held in
// the input register until the engine step writes its result to the result register.
// aresetn is synchronous and active low; it clears both stages and the engine state.
// A stalled result register stops the engine step, and the input register then
// holds its request so s_ready falls; cfg_ready is always high.
module i2c_master_byte_engine_unit import i2cm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_wdata
);

    logic      item_valid;
    in_item_t  item;
    out_item_t result;
    logic      can_load;
    logic      advance;

    // The engine steps when a request is held and the result register can take it.
    assign advance   = item_valid && can_load;
    assign cfg_ready = 1'b1;

    i2cm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    i2cm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A held request behind a stalled result must block the input side.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while both stages are stalled");

    // Each engine step produces a visible result in the next cycle.
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("engine step lost its result");

    // A finishing tick always leaves the engine idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.busy_res)
        else $error("done reported while still busy");

endmodule

FILE: dv/tb_i2c_master_byte_engine_unit.sv
module tb_i2c_master_byte_engine_unit;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RUN_LIMIT    = 400000;
    localparam int HOLD_AFTER   = 640;
    localparam int HOLD_CYCLES  = 300;

    // Command codes that the engine must ignore.
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // Unit positions inside one bit slot.
    localparam logic [2:0] UNIT_SAMPLE = 3'd2;
    localparam logic [2:0] UNIT_FALL   = 3'd3;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_wdata = '0;

    // Engine state as the predictor sees it.
    logic [7:0] unit_ticks  = TPU_RESET;
    logic [2:0] eng_cmd     = CMD_NONE;
    logic [7:0] div_cnt     = '0;
    logic [2:0] unit_ph     = '0;
    logic [3:0] slot_idx    = '0;
    logic [7:0] shifter     = '0;
    logic       scl_q       = 1'b1;
    logic       sda_q       = 1'b1;
    logic       nack_q      = 1'b0;
    logic       ack_latched = 1'b0;
    logic [7:0] rx_last     = '0;

    in_item_t    tick_q[$];
    out_item_t   pin_state_q[$];
    int          ticks_planned = 0;
    int          err_count     = 0;
    int unsigned cycle_cnt     = 0;
    int          results_seen  = 0;
    int          hold_left     = 0;
    logic        hold_fired    = 1'b0;
    int          snd_wait      = 0;
    int          snd_calm      = 0;
    int          rcv_wait      = 0;
    int          rcv_calm      = 0;

    i2c_master_byte_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Pin levels for the current unit of the active command.
    function automatic void drive_levels();
        case (eng_cmd)
            CMD_START: begin
                scl_q = (unit_ph < 3'd4);
                sda_q = (unit_ph < 3'd2);
            end
            CMD_STOP: begin
                if (unit_ph == 3'd0) begin
                    sda_q = 1'b0;
                end else if (unit_ph < UNIT_FALL) begin
                    scl_q = 1'b1;
                    sda_q = 1'b0;
                end else begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                end
            end
            default: begin
                if (unit_ph == 3'd0) begin
                    if (slot_idx < BIT_ACK_SLOT)
                        sda_q = (eng_cmd == CMD_WRITE) ? shifter[7] : 1'b1;
                    else
                        sda_q = (eng_cmd == CMD_WRITE) ? 1'b1 : ~ack_latched;
                end else begin
                    scl_q = (unit_ph < UNIT_FALL);
                end
            end
        endcase
    endfunction

    // Advance the engine by one bus tick and return the levels and status after it.
    function automatic out_item_t engine_tick(input in_item_t t);
        out_item_t r;
        logic      finished;
        int        ticks;
        int        units;
        int        slots;
        finished = 1'b0;
        if (eng_cmd == CMD_NONE) begin
            if (t.cmd >= CMD_START && t.cmd <= CMD_READ) begin
                eng_cmd  = t.cmd;
                unit_ph  = '0;
                slot_idx = '0;
                div_cnt  = '0;
                if (t.cmd == CMD_WRITE)
                    shifter = t.tx_byte;
                if (t.cmd == CMD_READ) begin
                    shifter     = '0;
                    ack_latched = t.ack_after_read;
                end
                drive_levels();
            end
        end else begin
            ticks = (unit_ticks == 8'd0) ? 1 : int'(unit_ticks);
            units = (eng_cmd == CMD_START || eng_cmd == CMD_STOP) ?
                    int'(UNITS_COND) : int'(UNITS_BYTE);
            slots = (eng_cmd == CMD_START || eng_cmd == CMD_STOP) ?
                    int'(SLOTS_COND) : int'(SLOTS_BYTE);
            if (int'(div_cnt) + 1 >= ticks) begin
                div_cnt = '0;
                // Sampling happens at the end of the second SCL-high unit.
                if (unit_ph == UNIT_SAMPLE) begin
                    if (eng_cmd == CMD_WRITE && slot_idx == BIT_ACK_SLOT)
                        nack_q = t.sda_in;
                    if (eng_cmd == CMD_READ && slot_idx < BIT_ACK_SLOT) begin
                        shifter = {shifter[6:0], t.sda_in};
                        if (slot_idx == BIT_LAST_DATA)
                            rx_last = shifter;
                    end
                end
                if (unit_ph == UNIT_FALL && eng_cmd == CMD_WRITE && slot_idx < BIT_ACK_SLOT)
                    shifter = shifter << 1;
                unit_ph = unit_ph + 3'd1;
                if (int'(unit_ph) >= units) begin
                    unit_ph  = '0;
                    slot_idx = slot_idx + 4'd1;
                    if (int'(slot_idx) >= slots) begin
                        slot_idx = '0;
                        eng_cmd  = CMD_NONE;
                        finished = 1'b1;
                    end
                end
                if (eng_cmd != CMD_NONE)
                    drive_levels();
            end else begin
                div_cnt = div_cnt + 8'd1;
            end
        end
        r.scl_level   = scl_q;
        r.sda_release = sda_q;
        r.busy_res    = (eng_cmd != CMD_NONE);
        r.done_res    = finished;
        r.rx_byte     = rx_last;
        r.nack_seen   = nack_q;
        return r;
    endfunction

    // Idle cycles before the next request, with occasional stretches of none.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("cycle %0d: %s", cycle_cnt, msg);
        err_count = err_count + 1;
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pin_state_q.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with none expected", got));
        end else begin
            want = pin_state_q.pop_front();
            cmp_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
            cmp_field("sda_release", 8'(got.sda_release), 8'(want.sda_release));
            cmp_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            cmp_field("done_res", 8'(got.done_res), 8'(want.done_res));
            cmp_field("rx_byte", got.rx_byte, want.rx_byte);
            cmp_field("nack_seen", 8'(got.nack_seen), 8'(want.nack_seen));
        end
    endtask

    // Length of a command in bus ticks at the current speed.
    function automatic int cmd_ticks(input logic [2:0] c);
        int units;
        units = (c == CMD_START || c == CMD_STOP) ? 5 : 36;
        return units * ((unit_ticks == 8'd0) ? 1 : int'(unit_ticks));
    endfunction

    task automatic push_tick(input logic [2:0] c, input logic [7:0] tx, input logic ack,
                             input logic sda);
        in_item_t t;
        t.cmd            = c;
        t.tx_byte        = tx;
        t.ack_after_read = ack;
        t.sda_in         = sda;
        tick_q.push_back(t);
        ticks_planned = ticks_planned + 1;
    endtask

    // Ticks with random pin data; with any_code set the command field may hold any code,
    // otherwise only codes that are never accepted.
    task automatic add_ticks(input int n, input logic any_code);
        logic [2:0] c;
        repeat (n) begin
            c = 3'($urandom_range(0, 7));
            if (!any_code && c < CMD_RSVD5)
                c = CMD_NONE;
            push_tick(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // A command followed by filler for its duration, shortened by cut ticks so that
    // the next request lands on the done tick or in the middle of the command.
    task automatic add_command(input logic [2:0] c, input logic [7:0] tx, input logic ack,
                               input int cut);
        push_tick(c, tx, ack, 1'($urandom_range(0, 1)));
        add_ticks(cmd_ticks(c) - 1 - cut, 1'b1);
    endtask

    task automatic random_phase(input int budget);
        int         stop_at;
        int         sel;
        int         cut;
        logic [2:0] c;
        stop_at = ticks_planned + budget;
        while (ticks_planned < stop_at) begin
            c   = 3'($urandom_range(int'(CMD_START), int'(CMD_READ)));
            sel = $urandom_range(0, 9);
            if (sel < 8)
                cut = 0;
            else if (sel == 8)
                cut = 1;
            else
                cut = $urandom_range(2, cmd_ticks(c) - 1);
            add_command(c, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cut);
            add_ticks($urandom_range(0, 3), 1'b0);
        end
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic drain();
        while (tick_q.size() != 0 || s_valid || pin_state_q.size() != 0)
            @(posedge aclk);
    endtask

    // Write the speed register with the pipeline empty and the engine idle.
    task automatic set_unit_ticks(input logic [7:0] v);
        drain();
        while (eng_cmd != CMD_NONE) begin
            add_ticks(16, 1'b0);
            drain();
        end
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        unit_ticks = v;
        cfg_valid <= 1'b0;
    endtask

    // Request driver: each accepted request steps the predictor.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                pin_state_q.push_back(engine_tick(s_data));
            if (!s_valid || s_ready) begin
                if (snd_wait != 0) begin
                    snd_wait = snd_wait - 1;
                    s_valid <= 1'b0;
                end else if (tick_q.size() != 0) begin
                    s_data  <= tick_q.pop_front();
                    s_valid <= 1'b1;
                    snd_wait = draw_gap(snd_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
                results_seen <= results_seen + 1;
                rcv_wait = draw_gap(rcv_calm);
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (rcv_wait != 0) begin
                rcv_wait = rcv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off part way through, so the block fills and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && results_seen >= HOLD_AFTER) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("i2c_master_byte_engine_unit verification failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset speed: ignored codes while idle, then a start condition.
        push_tick(CMD_RSVD5, 8'h00, 1'b0, 1'b0);
        push_tick(CMD_RSVD6, 8'hFF, 1'b1, 1'b1);
        push_tick(CMD_RSVD7, 8'h00, 1'b1, 1'b0);
        push_tick(CMD_NONE, 8'hFF, 1'b0, 1'b1);
        add_command(CMD_START, 8'h5A, 1'b0, 0);
        add_ticks(2, 1'b0);

        // Fastest speed: every command, byte extremes and both ACK choices.
        set_unit_ticks(8'd1);
        add_command(CMD_START, 8'h00, 1'b0, 0);
        add_command(CMD_WRITE, 8'h00, 1'b0, 0);
        add_command(CMD_WRITE, 8'hFF, 1'b1, 0);
        add_command(CMD_WRITE, 8'hA5, 1'b0, 0);
        add_command(CMD_READ, 8'h00, 1'b1, 0);
        add_command(CMD_READ, 8'hFF, 1'b0, 0);
        // A request on the last tick before the done tick is dropped.
        add_command(CMD_STOP, 8'h3C, 1'b1, 1);
        push_tick(CMD_WRITE, 8'h81, 1'b0, 1'b1);
        add_ticks(2, 1'b0);
        // A request in the middle of a read is dropped.
        add_command(CMD_READ, 8'h7E, 1'b1, 20);
        push_tick(CMD_START, 8'h18, 1'b0, 1'b0);
        add_ticks(25, 1'b0);
        add_command(CMD_STOP, 8'hC3, 1'b0, 0);

        // A zero speed setting behaves as one tick per unit.
        set_unit_ticks(8'd0);
        random_phase(80);
        set_unit_ticks(8'd1);
        random_phase(140);
        set_unit_ticks(8'd2);
        random_phase(100);
        set_unit_ticks(8'd3);
        random_phase(80);
        set_unit_ticks(8'($urandom_range(4, 8)));
        random_phase(60);
        set_unit_ticks(8'd1);
        random_phase(60);

        // Slowest speed: the first unit boundary of a bus condition.
        set_unit_ticks(8'd255);
        add_command(CMD_STOP, 8'hFF, 1'b1, cmd_ticks(CMD_STOP) - 301);
        add_ticks(4, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("i2c_master_byte_engine_unit verification clean");
        else
            $display("i2c_master_byte_engine_unit verification failed");
        $finish;
    end

endmodule
